/* design/cmhp_pkg.sv */
package cmhp_pkg;

	typedef enum logic [2:0] {
		PH_SOC_HI, PH_SOC_LO, PH_MARK_HI, PH_MARK_LO, PH_LEN_HI, PH_LEN_LO, PH_BODY
	} phase_t;

	localparam logic [15:0] MK_SOT = 16'hFF90;
	localparam logic [15:0] MK_SIZ = 16'hFF51;
	localparam logic [15:0] MK_COD = 16'hFF52;
	localparam logic [15:0] MK_QCD = 16'hFF5C;
	localparam logic [15:0] MK_QCC = 16'hFF5D;

	localparam logic [2:0] KIND_COMP = 3'd0;
	localparam logic [2:0] KIND_COD  = 3'd1;
	localparam logic [2:0] KIND_QNT  = 3'd2;
	localparam logic [2:0] KIND_BAND = 3'd3;
	localparam logic [2:0] KIND_DONE = 3'd4;

	localparam logic [3:0] ST_OK      = 4'd0;
	localparam logic [3:0] ST_NO_SOC  = 4'd1;
	localparam logic [3:0] ST_BAD_MK  = 4'd2;
	localparam logic [3:0] ST_BAD_LEN = 4'd3;
	localparam logic [3:0] ST_SIZ_SH  = 4'd4;
	localparam logic [3:0] ST_COD_SH  = 4'd5;
	localparam logic [3:0] ST_QNT_SH  = 4'd6;
	localparam logic [3:0] ST_BAD_STY = 4'd7;
	localparam logic [3:0] ST_MISSING = 4'd8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  record_kind;
		logic [15:0] component;
		logic [15:0] band;
		logic [7:0]  field_a;
		logic [10:0] field_b;
		logic [7:0]  field_c;
		logic [3:0]  status;
		logic        run_last;
	} rec_t;

	// results of one byte: up to two records
	typedef struct packed {
		logic [1:0] count;
		rec_t       r0;
		rec_t       r1;
	} pair_t;

endpackage

/* design/cmhp_if.sv */
interface cmhp_in_if import cmhp_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cmhp_out_if import cmhp_pkg::*; ();
	logic valid;
	logic ready;
	rec_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/cmhp_core.sv */
module cmhp_core import cmhp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output pair_t    res
);
	phase_t      phase_q, phase_d;
	logic [15:0] mark_q, mark_d, len_q, len_d, pos_q, pos_d, ncomp_q, ncomp_d;
	logic [15:0] owner_q, owner_d, bandc_q, bandc_d, held_q, held_d;
	logic [1:0]  style_q, style_d;
	logic [2:0]  seen_q, seen_d;
	logic        fin_q, fin_d;
	logic [3:0]  pend_q, pend_d;

	// sequential component slot tracking instead of divide by 3
	logic [15:0] cidx_q, cidx_d;
	logic [1:0]  crem_q, crem_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SOC_HI; mark_q <= '0; len_q <= '0; pos_q <= '0;
			ncomp_q <= '0; owner_q <= '0; bandc_q <= '0; held_q <= '0;
			style_q <= '0; seen_q <= '0; fin_q <= 1'b0; pend_q <= '0;
			cidx_q <= '0; crem_q <= '0;
		end else if (step) begin
			phase_q <= phase_d; mark_q <= mark_d; len_q <= len_d; pos_q <= pos_d;
			ncomp_q <= ncomp_d; owner_q <= owner_d; bandc_q <= bandc_d; held_q <= held_d;
			style_q <= style_d; seen_q <= seen_d; fin_q <= fin_d; pend_q <= pend_d;
			cidx_q <= cidx_d; crem_q <= crem_d;
		end
	end

	logic [7:0]  b;
	logic        eos;
	logic [15:0] mk, blen, k;
	logic [1:0]  ilen;
	logic        isq;
	logic [3:0]  st;
	logic [17:0] need;
	rec_t        rec [2];
	logic [1:0]  n;

	function automatic rec_t mkrec(logic [2:0] kind, logic [15:0] c, logic [15:0] bd,
		logic [7:0] a, logic [10:0] fb, logic [7:0] fc, logic [3:0] s);
		rec_t r;
		r = '{kind, c, bd, a, fb, fc, s, 1'b0};
		return r;
	endfunction

	always_comb begin
		b = item.data_byte; eos = item.end_of_stream;
		phase_d = phase_q; mark_d = mark_q; len_d = len_q; pos_d = pos_q;
		ncomp_d = ncomp_q; owner_d = owner_q; bandc_d = bandc_q; held_d = held_q;
		style_d = style_q; seen_d = seen_q; fin_d = fin_q; pend_d = pend_q;
		cidx_d = cidx_q; crem_d = crem_q;
		rec[0] = '0; rec[1] = '0; n = 2'd0;
		mk = mark_q; blen = len_q - 16'd2; k = '0; st = ST_OK; need = '0;
		isq = (mark_q == MK_QCD) || (mark_q == MK_QCC);
		ilen = (mark_q == MK_QCC) ? ((ncomp_q < 16'd257) ? 2'd1 : 2'd2) : 2'd0;
		if (!fin_q) begin
			case (phase_q)
				PH_SOC_HI: begin
					if (b != 8'hFF || eos) begin
						rec[0] = mkrec(KIND_DONE, '0, '0, '0, '0, '0, ST_NO_SOC);
						n = 2'd1; fin_d = 1'b1;
					end else phase_d = PH_SOC_LO;
				end
				PH_SOC_LO: begin
					if (b != 8'h4F || eos) begin
						rec[0] = mkrec(KIND_DONE, '0, '0, '0, '0, '0, (b != 8'h4F) ? ST_NO_SOC
							: ((seen_q == 3'b111) ? ST_OK : ST_MISSING));
						n = 2'd1; fin_d = 1'b1;
					end else phase_d = PH_MARK_HI;
				end
				PH_MARK_HI: begin
					mark_d = {b, 8'h00};
					if (eos) begin
						rec[0] = mkrec(KIND_DONE, '0, '0, '0, '0, '0,
							(seen_q == 3'b111) ? ST_OK : ST_MISSING);
						n = 2'd1; fin_d = 1'b1;
					end else phase_d = PH_MARK_LO;
				end
				PH_MARK_LO: begin
					mk = {mark_q[15:8], b};
					mark_d = mk;
					if (mk == MK_SOT || eos) begin
						rec[0] = mkrec(KIND_DONE, '0, '0, '0, '0, '0,
							(seen_q == 3'b111) ? ST_OK : ST_MISSING);
						n = 2'd1; fin_d = 1'b1;
					end else phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_d = {b, 8'h00};
					if (eos) begin
						rec[0] = mkrec(KIND_DONE, '0, '0, '0, '0, '0,
							(seen_q == 3'b111) ? ST_OK : ST_MISSING);
						n = 2'd1; fin_d = 1'b1;
					end else phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d = {len_q[15:8], b};
					if (mark_q[15:8] != 8'hFF) begin
						rec[0] = mkrec(KIND_DONE, '0, '0, '0, '0, '0, ST_BAD_MK);
						n = 2'd1; fin_d = 1'b1;
					end else if (len_d < 16'd2) begin
						rec[0] = mkrec(KIND_DONE, '0, '0, '0, '0, '0, ST_BAD_LEN);
						n = 2'd1; fin_d = 1'b1;
					end else begin
						pos_d = '0; pend_d = '0; bandc_d = '0; held_d = '0; style_d = '0;
						cidx_d = '0; crem_d = '0;
						owner_d = (mark_q == MK_QCD) ? 16'hFFFF : 16'h0000;
						if (len_d == 16'd2) begin
							// empty body: segment end check at once
							st = ST_OK;
							if (mark_q == MK_SIZ) st = ST_SIZ_SH;
							else if (mark_q == MK_COD) st = ST_COD_SH;
							else if (isq) st = ST_QNT_SH;
							if (st != ST_OK) begin
								rec[0] = mkrec(KIND_DONE, '0, '0, '0, '0, '0, st);
								n = 2'd1; fin_d = 1'b1;
							end else if (eos) begin
								rec[0] = mkrec(KIND_DONE, '0, '0, '0, '0, '0,
									(seen_q == 3'b111) ? ST_OK : ST_MISSING);
								n = 2'd1; fin_d = 1'b1;
							end else phase_d = PH_MARK_HI;
						end else if (eos) begin
							rec[0] = mkrec(KIND_DONE, '0, '0, '0, '0, '0, ST_BAD_LEN);
							n = 2'd1; fin_d = 1'b1;
						end else phase_d = PH_BODY;
					end
				end
				PH_BODY: begin
					// body byte
					if (mark_q == MK_SIZ) begin
						if (pos_q == 16'd34) held_d = {b, 8'h00};
						else if (pos_q == 16'd35) ncomp_d = held_q | {8'h00, b};
						else if (pos_q >= 16'd36) begin
							if (cidx_q < ncomp_q) begin
								case (crem_q)
									2'd0: held_d = {8'h00, b};
									2'd1: held_d = {b, held_q[7:0]};
									default: begin
										rec[0] = mkrec(KIND_COMP, cidx_q, '0, held_q[7:0],
											{3'b000, held_q[15:8]}, b, ST_OK);
										n = 2'd1;
									end
								endcase
							end
							if (crem_q == 2'd2) begin
								crem_d = 2'd0; cidx_d = cidx_q + 16'd1;
							end else crem_d = crem_q + 2'd1;
						end
					end else if (mark_q == MK_COD) begin
						if (pos_q == 16'd4) held_d = {7'd0, b != 8'd0, held_q[7:0]};
						else if (pos_q == 16'd5) held_d = {7'd0, held_q[8], b};
						else if (pos_q == 16'd9) begin
							rec[0] = mkrec(KIND_COD, '0, '0, held_q[7:0], {3'b000, b},
								{7'd0, held_q[8]}, ST_OK);
							n = 2'd1;
						end
					end else if (isq) begin
						k = pos_q - {14'd0, ilen} - 16'd1;
						if (pos_q < {14'd0, ilen}) begin
							if (ilen == 2'd1) owner_d = {8'h00, b};
							else if (pos_q == 16'd0) owner_d = {b, 8'h00};
							else owner_d = {owner_q[15:8], b};
						end else if (pos_q == {14'd0, ilen}) begin
							rec[0] = mkrec(KIND_QNT, owner_q, '0, {3'b000, b[4:0]},
								{8'd0, b[7:5]}, '0, ST_OK);
							n = 2'd1;
							if (b[4:0] > 5'd2) pend_d = ST_BAD_STY;
							else style_d = b[1:0];
						end else if (pend_q == ST_OK) begin
							if (style_q == 2'd0) begin
								rec[0] = mkrec(KIND_BAND, owner_q, bandc_q, {3'b000, b[7:3]},
									'0, '0, ST_OK);
								n = 2'd1; bandc_d = bandc_q + 16'd1;
							end else if (style_q == 2'd1 && k < 16'd2) begin
								if (k == 16'd0) held_d = {8'h00, b};
								else begin
									rec[0] = mkrec(KIND_BAND, owner_q, '0, {3'b000, held_q[7:3]},
										{held_q[2:0], b}, '0, ST_OK);
									n = 2'd1;
								end
							end else if (style_q == 2'd2) begin
								if (!k[0]) held_d = {8'h00, b};
								else begin
									rec[0] = mkrec(KIND_BAND, owner_q, bandc_q,
										{3'b000, held_q[7:3]}, {held_q[2:0], b}, '0, ST_OK);
									n = 2'd1; bandc_d = bandc_q + 16'd1;
								end
							end
						end
					end
					// segment end
					if (pos_q + 16'd1 == blen) begin
						st = pend_d;
						need = 18'd36 + {1'b0, ncomp_d, 1'b0} + {2'b00, ncomp_d};
						if (st == ST_OK) begin
							if (mark_q == MK_SIZ) begin
								if ({2'b00, blen} < need) st = ST_SIZ_SH;
							end else if (mark_q == MK_COD) begin
								if (blen < 16'd10) st = ST_COD_SH;
							end else if (isq) begin
								if (blen < {14'd0, ilen} + 16'd1) st = ST_QNT_SH;
								else if (style_d == 2'd1 && blen < {14'd0, ilen} + 16'd3)
									st = ST_QNT_SH;
							end
						end
						if (st != ST_OK) begin
							rec[n[0]] = mkrec(KIND_DONE, '0, '0, '0, '0, '0, st);
							n = n + 2'd1; fin_d = 1'b1;
						end else begin
							if (mark_q == MK_SIZ) seen_d[0] = 1'b1;
							else if (mark_q == MK_COD) seen_d[1] = 1'b1;
							else if (isq && owner_d == 16'hFFFF) seen_d[2] = 1'b1;
							if (eos) begin
								rec[n[0]] = mkrec(KIND_DONE, '0, '0, '0, '0, '0,
									(seen_d == 3'b111) ? ST_OK : ST_MISSING);
								n = n + 2'd1; fin_d = 1'b1;
							end else phase_d = PH_MARK_HI;
						end
					end else if (eos) begin
						rec[n[0]] = mkrec(KIND_DONE, '0, '0, '0, '0, '0, ST_BAD_LEN);
						n = n + 2'd1; fin_d = 1'b1;
					end else pos_d = pos_q + 16'd1;
				end
				default: ;
			endcase
		end
		if (n == 2'd1) rec[0].run_last = 1'b1;
		if (n == 2'd2) rec[1].run_last = 1'b1;
		res.count = n; res.r0 = rec[0]; res.r1 = rec[1];
	end
endmodule

/* design/cmhp_outq.sv */
module cmhp_outq import cmhp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  pair_t res,
	output logic  can_load,
	output logic  valid,
	output rec_t  data,
	input  logic  ready
);
	// two-slot record buffer holding the records of one byte
	logic [1:0] cnt_q;
	rec_t       a_q, b_q;
	logic       pop;

	assign valid    = cnt_q != 2'd0;
	assign data     = a_q;
	assign pop      = valid && ready;
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load && can_load) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			a_q <= res.r0;
			b_q <= res.r1;
		end else if (pop) begin
			a_q <= b_q;
		end
	end
endmodule

/* design/codestream_main_header_parser.sv */
// codestream main header parser: one codestream byte per transfer
// latency: the first record of a byte appears the cycle after its transfer
// throughput: one byte per cycle while the byte yields at most one record and out_ch is ready;
// a byte with two records holds input until only its second record is left and is being taken (two-slot output buffer)
// reset: asynchronous arst_n returns to the expect-SOC phase with all flags clear
module codestream_main_header_parser import cmhp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	cmhp_in_if.sink   in_ch,
	cmhp_out_if.source out_ch
);
	pair_t res;
	logic  can_load;
	logic  step;

	// a byte is taken only when the buffer can hold all its records
	assign in_ch.ready = can_load;
	assign step        = in_ch.valid && can_load;

	// parse state and record formation
	cmhp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (in_ch.data),
		.res    (res)
	);

	// result buffer; a byte with no record just passes
	cmhp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.res      (res),
		.can_load (can_load),
		.valid    (out_ch.valid),
		.data     (out_ch.data),
		.ready    (out_ch.ready)
	);
endmodule
